FILE: src/afd_pkg.sv
`default_nettype none
package afd_pkg;

  localparam int unsigned PAYLOAD_LIMIT_DEF = 1024 * 1024;
  localparam logic [31:0] HDR_MAGIC = 32'h3154_4143;
  localparam logic [15:0] HDR_VERSION = 16'd1;
  localparam logic [4:0] HEADER_LAST = 5'd19;

  localparam logic [15:0] KIND_MIN = 16'd1;
  localparam logic [15:0] KIND_MAX = 16'd4;

  localparam logic [2:0] ST_BUSY = 3'd0;
  localparam logic [2:0] ST_HDR_OK = 3'd1;
  localparam logic [2:0] ST_FRAME_OK = 3'd2;
  localparam logic [2:0] ST_HDR_ERR = 3'd3;
  localparam logic [2:0] ST_BODY_ERR = 3'd4;
  localparam logic [2:0] ST_HALTED = 3'd5;

  localparam logic [1:0] SEC_HEADER = 2'd0;
  localparam logic [1:0] SEC_PREFIX = 2'd1;
  localparam logic [1:0] SEC_CONTENT = 2'd2;
  localparam logic [1:0] SEC_HALT = 2'd3;

  localparam logic [1:0] FIELD_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind_code;
    logic [63:0] trans_id;
    logic [20:0] body_size;
    logic [1:0]  section;
    logic [1:0]  field_index;
    logic [7:0]  data_byte;
    logic        field_end;
  } result_t;

endpackage
`default_nettype wire

FILE: src/attestation_frame_deframer_unit.sv
// Byte-serial attestation frame deframer. One received byte is taken per clock and
// yields exactly one result, in the next cycle, from a single output register; a new
// byte is accepted whenever that register is empty or being emptied, so the sustained
// rate is one byte per cycle, set only by the downstream ready. A frame is a 20-byte
// little-endian header (magic, version, kind, transcript id, payload size) followed by
// three length-prefixed fields. Header ok reports kind, id and size; frame ok marks the
// byte that closes the body. Any header or body error halts the block until reset.
`default_nettype none
module attestation_frame_deframer_unit #(
  parameter int unsigned PAYLOAD_LIMIT = afd_pkg::PAYLOAD_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [2:0]       kind_code,
  output logic [63:0]      trans_id,
  output logic [20:0]      body_size,
  output logic [1:0]       section,
  output logic [1:0]       field_index,
  output logic [7:0]       data_byte,
  output logic             field_end
);

  logic             take;
  afd_pkg::result_t res;
  afd_pkg::result_t held;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  afd_core #(
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .take(take),
    .rx_byte(rx_byte),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= res;
    end
  end

  assign status = held.status;
  assign kind_code = held.kind_code;
  assign trans_id = held.trans_id;
  assign body_size = held.body_size;
  assign section = held.section;
  assign field_index = held.field_index;
  assign data_byte = held.data_byte;
  assign field_end = held.field_end;

endmodule
`default_nettype wire

FILE: src/afd_core.sv
`default_nettype none
module afd_core #(
  parameter int unsigned PAYLOAD_LIMIT = afd_pkg::PAYLOAD_LIMIT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      rx_byte,
  output afd_pkg::result_t     res
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_LIMIT + 1);
  localparam logic [31:0] SIZE_CAP = 32'(PAYLOAD_LIMIT);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_CONTENT = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [4:0]       header_count, header_count_next;
  logic [CNT_W-1:0] body_remaining, body_remaining_next;
  logic [1:0]       field_number, field_number_next;
  logic [1:0]       prefix_count, prefix_count_next;
  logic [CNT_W-1:0] field_remaining, field_remaining_next;

  // header and prefix bytes are overwritten in place, so no clear is needed
  logic [31:0] magic_acc;
  logic [15:0] version_acc;
  logic [15:0] kind_acc;
  logic [63:0] transcript_acc;
  logic [23:0] size_acc;
  logic [23:0] prefix_value;

  logic [31:0]      size_full;
  logic [31:0]      prefix_full;
  logic [CNT_W-1:0] body_dec;
  logic [CNT_W-1:0] field_dec;
  logic             header_ok;
  logic             field_done;

  assign size_full = {rx_byte, size_acc};
  assign prefix_full = {rx_byte, prefix_value};
  assign body_dec = (body_remaining != '0) ? body_remaining - 1'b1 : body_remaining;
  assign field_dec = (field_remaining != '0) ? field_remaining - 1'b1 : field_remaining;
  assign header_ok = (magic_acc == afd_pkg::HDR_MAGIC) &&
                     (version_acc == afd_pkg::HDR_VERSION) &&
                     (size_full <= SIZE_CAP) &&
                     (kind_acc >= afd_pkg::KIND_MIN) && (kind_acc <= afd_pkg::KIND_MAX);

  always_comb begin
    phase_next = phase;
    header_count_next = header_count;
    body_remaining_next = body_remaining;
    field_number_next = field_number;
    prefix_count_next = prefix_count;
    field_remaining_next = field_remaining;
    field_done = 1'b0;
    res = '0;
    res.data_byte = rx_byte;
    res.status = afd_pkg::ST_BUSY;

    case (phase)
      PH_HEADER: begin
        res.section = afd_pkg::SEC_HEADER;
        if (header_count == afd_pkg::HEADER_LAST) begin
          if (!header_ok) begin
            res.status = afd_pkg::ST_HDR_ERR;
            phase_next = PH_HALT;
          end else if (size_full == '0) begin
            res.status = afd_pkg::ST_BODY_ERR;
            phase_next = PH_HALT;
          end else begin
            res.status = afd_pkg::ST_HDR_OK;
            res.kind_code = kind_acc[2:0];
            res.trans_id = transcript_acc;
            res.body_size = size_full[20:0];
            body_remaining_next = size_full[CNT_W-1:0];
            field_number_next = '0;
            prefix_count_next = '0;
            field_remaining_next = '0;
            phase_next = PH_PREFIX;
          end
        end else begin
          header_count_next = header_count + 1'b1;
        end
      end
      PH_PREFIX: begin
        res.section = afd_pkg::SEC_PREFIX;
        res.field_index = field_number;
        body_remaining_next = body_dec;
        if (prefix_count == 2'd3) begin
          if (prefix_full > 32'(body_dec)) begin
            res.status = afd_pkg::ST_BODY_ERR;
            phase_next = PH_HALT;
          end else if (prefix_full == '0) begin
            field_done = 1'b1;
          end else begin
            field_remaining_next = prefix_full[CNT_W-1:0];
            phase_next = PH_CONTENT;
          end
        end else if (body_dec == '0) begin
          res.status = afd_pkg::ST_BODY_ERR;
          phase_next = PH_HALT;
        end else begin
          prefix_count_next = prefix_count + 1'b1;
        end
      end
      PH_CONTENT: begin
        res.section = afd_pkg::SEC_CONTENT;
        res.field_index = field_number;
        body_remaining_next = body_dec;
        field_remaining_next = field_dec;
        if (field_dec == '0) begin
          res.field_end = 1'b1;
          field_done = 1'b1;
        end
      end
      default: begin
        res.status = afd_pkg::ST_HALTED;
        res.section = afd_pkg::SEC_HALT;
        res.data_byte = '0;
      end
    endcase

    // close the field: next field, end of frame, or body length mismatch
    if (field_done) begin
      if (field_number >= afd_pkg::FIELD_PAYLOAD) begin
        if (body_dec == '0) begin
          res.status = afd_pkg::ST_FRAME_OK;
          header_count_next = '0;
          field_number_next = '0;
          prefix_count_next = '0;
          field_remaining_next = '0;
          phase_next = PH_HEADER;
        end else begin
          res.status = afd_pkg::ST_BODY_ERR;
          phase_next = PH_HALT;
        end
      end else begin
        field_number_next = field_number + 1'b1;
        prefix_count_next = '0;
        field_remaining_next = '0;
        phase_next = PH_PREFIX;
        if (body_dec == '0) begin
          res.status = afd_pkg::ST_BODY_ERR;
          phase_next = PH_HALT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_count <= '0;
      body_remaining <= '0;
      field_number <= '0;
      prefix_count <= '0;
      field_remaining <= '0;
    end else if (take) begin
      phase <= phase_next;
      header_count <= header_count_next;
      body_remaining <= body_remaining_next;
      field_number <= field_number_next;
      prefix_count <= prefix_count_next;
      field_remaining <= field_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && phase == PH_HEADER) begin
      if (header_count < 5'd4) begin
        magic_acc[header_count[1:0]*8 +: 8] <= rx_byte;
      end else if (header_count < 5'd6) begin
        version_acc[header_count[0]*8 +: 8] <= rx_byte;
      end else if (header_count < 5'd8) begin
        kind_acc[header_count[0]*8 +: 8] <= rx_byte;
      end else if (header_count < 5'd16) begin
        transcript_acc[header_count[2:0]*8 +: 8] <= rx_byte;
      end else if (header_count < afd_pkg::HEADER_LAST) begin
        size_acc[header_count[1:0]*8 +: 8] <= rx_byte;
      end
    end
    if (take && phase == PH_PREFIX && prefix_count != 2'd3) begin
      prefix_value[prefix_count*8 +: 8] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

FILE: src/afd_checker.sv
`default_nettype none
module afd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [2:0]  kind_code,
  input wire logic [63:0] trans_id,
  input wire logic [20:0] body_size,
  input wire logic [1:0]  section,
  input wire logic        field_end
);

  // a stalled result stays on offer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == afd_pkg::ST_HALTED |-> section == afd_pkg::SEC_HALT)
    else $error("halted status outside halted section");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == afd_pkg::ST_HDR_OK |->
      kind_code >= 3'd1 && kind_code <= 3'd4 && body_size != '0)
    else $error("header ok with bad kind or empty size");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != afd_pkg::ST_HDR_OK |->
      kind_code == '0 && trans_id == '0 && body_size == '0)
    else $error("header fields leak outside header ok");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && field_end |-> section == afd_pkg::SEC_CONTENT)
    else $error("field end outside content");

endmodule

bind attestation_frame_deframer_unit afd_checker u_afd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status(status),
  .kind_code(kind_code),
  .trans_id(trans_id),
  .body_size(body_size),
  .section(section),
  .field_end(field_end)
);
`default_nettype wire
